>>> design/gpred_pkg.sv
// Shared types, codes and decode functions for the geometry predicate unit.
package gpred_pkg;

  localparam int unsigned TOL_W = 62;

  typedef enum logic [1:0] {
    OP_ORIENT   = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_CONE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ORI_COLLINEAR = 2'd0,
    ORI_LEFT      = 2'd1,
    ORI_RIGHT     = 2'd2
  } ori_e;

  typedef enum logic [2:0] {
    TRI_OUTSIDE  = 3'd0,
    TRI_INSIDE   = 3'd1,
    TRI_EDGE_AB  = 3'd2,
    TRI_EDGE_BC  = 3'd3,
    TRI_EDGE_CA  = 3'd4,
    TRI_VERTEX_A = 3'd5,
    TRI_VERTEX_B = 3'd6,
    TRI_VERTEX_C = 3'd7
  } tri_e;

  function automatic tri_e tri_relation(input ori_e o_ab, input ori_e o_bc, input ori_e o_ca);
    tri_e rel;
    if (o_ab == ORI_RIGHT || o_bc == ORI_RIGHT || o_ca == ORI_RIGHT) begin
      rel = TRI_OUTSIDE;
    end else if (o_ab == ORI_COLLINEAR) begin
      if (o_bc == ORI_COLLINEAR) begin
        rel = TRI_VERTEX_B;
      end else if (o_ca == ORI_COLLINEAR) begin
        rel = TRI_VERTEX_A;
      end else begin
        rel = TRI_EDGE_AB;
      end
    end else if (o_bc == ORI_COLLINEAR) begin
      if (o_ca == ORI_COLLINEAR) begin
        rel = TRI_VERTEX_C;
      end else begin
        rel = TRI_EDGE_BC;
      end
    end else if (o_ca == ORI_COLLINEAR) begin
      rel = TRI_EDGE_CA;
    end else begin
      rel = TRI_INSIDE;
    end
    return rel;
  endfunction

  function automatic logic cone_test(input ori_e o_qab, input ori_e o_qbc, input ori_e o_abc);
    logic r1;
    logic r2;
    r1 = (o_qab == ORI_RIGHT);
    r2 = (o_qbc == ORI_RIGHT);
    if (o_abc != ORI_RIGHT) begin
      return !r1 && !r2;
    end
    return !r1 || !r2;
  endfunction

endpackage

>>> design/gpred_det.sv
// Two-stage exact orientation determinant of three points.
module gpred_det import gpred_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned DET_W       = 2 * (COORD_WIDTH + 1) + 1
) (
  input  logic                          clk_i,
  input  logic signed [COORD_WIDTH-1:0] p1_x_i,
  input  logic signed [COORD_WIDTH-1:0] p1_y_i,
  input  logic signed [COORD_WIDTH-1:0] p2_x_i,
  input  logic signed [COORD_WIDTH-1:0] p2_y_i,
  input  logic signed [COORD_WIDTH-1:0] p3_x_i,
  input  logic signed [COORD_WIDTH-1:0] p3_y_i,
  output logic signed [DET_W-1:0]       det_o
);

  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;

  logic signed [DIFF_W-1:0] dx13;
  logic signed [DIFF_W-1:0] dy13;
  logic signed [DIFF_W-1:0] dx23;
  logic signed [DIFF_W-1:0] dy23;
  logic signed [PROD_W-1:0] prod1_q;
  logic signed [PROD_W-1:0] prod2_q;
  logic signed [DET_W-1:0]  det_q;

  assign dx13 = DIFF_W'(p1_x_i) - DIFF_W'(p3_x_i);
  assign dy13 = DIFF_W'(p1_y_i) - DIFF_W'(p3_y_i);
  assign dx23 = DIFF_W'(p2_x_i) - DIFF_W'(p3_x_i);
  assign dy23 = DIFF_W'(p2_y_i) - DIFF_W'(p3_y_i);

  always_ff @(posedge clk_i) begin
    prod1_q <= dx13 * dy23;
    prod2_q <= dy13 * dx23;
    det_q   <= DET_W'(prod1_q) - DET_W'(prod2_q);
  end

  assign det_o = det_q;

endmodule

>>> design/geometry_predicate_unit_core.sv
// Top level of the geometry predicate unit: input stage, determinants, result stage.
//
// One word is taken in every cycle (busy_o stays low). Its result is driven on
// done_o as the word leaves the last of its stages. The stages are an input
// register, the 33 by 33 bit multiplier stage, the 67 bit subtract stage of
// the determinant units, then the tolerance compare and decode into the
// result register. Three determinant units run side by side. The result
// strobe is one cycle wide and cannot be held off. Write the tolerance only
// while no word is in flight.
module geometry_predicate_unit_core import gpred_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        operation_i,
  input  logic [31:0]       q_x_i,
  input  logic [31:0]       q_y_i,
  input  logic [31:0]       a_x_i,
  input  logic [31:0]       a_y_i,
  input  logic [31:0]       b_x_i,
  input  logic [31:0]       b_y_i,
  input  logic [31:0]       c_x_i,
  input  logic [31:0]       c_y_i,
  input  logic              tol_we_i,
  input  logic [TOL_W-1:0]  tol_wdata_i,
  output logic              done_o,
  output logic [1:0]        orientation_o,
  output logic [2:0]        triangle_relation_o,
  output logic              in_cone_o
);

  localparam int unsigned DET_W = 2 * (COORD_WIDTH + 1) + 1;
  localparam int unsigned CMP_W = (DET_W > TOL_W + 1) ? DET_W : TOL_W + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  logic       v0_q, v1_q, v2_q, done_q;
  op_e        op0_q, op1_q, op2_q;
  coord_t     qx_q, qy_q, ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  coord_t     s3_p1x, s3_p1y, s3_p2x, s3_p2y;
  logic [TOL_W-1:0] tol_q;

  logic signed [DET_W-1:0] det1, det2, det3;
  logic signed [CMP_W-1:0] tol_eff;
  ori_e       o1, o2, o3;

  logic [1:0] orientation_d, orientation_q;
  logic [2:0] tri_d, tri_q;
  logic       cone_d, cone_q;

  function automatic ori_e classify(input logic signed [DET_W-1:0] det,
                                    input logic signed [CMP_W-1:0] tol);
    logic signed [CMP_W-1:0] d;
    ori_e o;
    d = CMP_W'(det);
    if (d <= tol && d >= -tol) begin
      o = ORI_COLLINEAR;
    end else if (d > 0) begin
      o = ORI_LEFT;
    end else begin
      o = ORI_RIGHT;
    end
    return o;
  endfunction

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
      tol_q  <= '0;
    end else begin
      v0_q   <= start_i && !busy_o;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      done_q <= v2_q;
      if (tol_we_i) begin
        tol_q <= tol_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op0_q <= op_e'(operation_i);
    op1_q <= op0_q;
    op2_q <= op1_q;
    qx_q  <= q_x_i[COORD_WIDTH-1:0];
    qy_q  <= q_y_i[COORD_WIDTH-1:0];
    ax_q  <= a_x_i[COORD_WIDTH-1:0];
    ay_q  <= a_y_i[COORD_WIDTH-1:0];
    bx_q  <= b_x_i[COORD_WIDTH-1:0];
    by_q  <= b_y_i[COORD_WIDTH-1:0];
    cx_q  <= c_x_i[COORD_WIDTH-1:0];
    cy_q  <= c_y_i[COORD_WIDTH-1:0];
    orientation_q <= orientation_d;
    tri_q         <= tri_d;
    cone_q        <= cone_d;
  end

  // third unit: edge ca for triangle, a-b-c for orient and cone
  always_comb begin
    if (op0_q == OP_TRIANGLE) begin
      s3_p1x = cx_q;
      s3_p1y = cy_q;
      s3_p2x = ax_q;
      s3_p2y = ay_q;
    end else begin
      s3_p1x = ax_q;
      s3_p1y = ay_q;
      s3_p2x = bx_q;
      s3_p2y = by_q;
    end
  end

  gpred_det #(.COORD_WIDTH(COORD_WIDTH), .DET_W(DET_W)) u_det_ab (
    .clk_i  (clk_i),
    .p1_x_i (ax_q), .p1_y_i (ay_q),
    .p2_x_i (bx_q), .p2_y_i (by_q),
    .p3_x_i (qx_q), .p3_y_i (qy_q),
    .det_o  (det1)
  );

  gpred_det #(.COORD_WIDTH(COORD_WIDTH), .DET_W(DET_W)) u_det_bc (
    .clk_i  (clk_i),
    .p1_x_i (bx_q), .p1_y_i (by_q),
    .p2_x_i (cx_q), .p2_y_i (cy_q),
    .p3_x_i (qx_q), .p3_y_i (qy_q),
    .det_o  (det2)
  );

  gpred_det #(.COORD_WIDTH(COORD_WIDTH), .DET_W(DET_W)) u_det_s3 (
    .clk_i  (clk_i),
    .p1_x_i (s3_p1x), .p1_y_i (s3_p1y),
    .p2_x_i (s3_p2x), .p2_y_i (s3_p2y),
    .p3_x_i (op0_q == OP_TRIANGLE ? qx_q : cx_q),
    .p3_y_i (op0_q == OP_TRIANGLE ? qy_q : cy_q),
    .det_o  (det3)
  );

  assign tol_eff = (op2_q == OP_CONE) ? '0 : $signed(CMP_W'(tol_q));
  assign o1 = classify(det1, tol_eff);
  assign o2 = classify(det2, tol_eff);
  assign o3 = classify(det3, tol_eff);

  always_comb begin
    orientation_d = ORI_COLLINEAR;
    tri_d         = TRI_OUTSIDE;
    cone_d        = 1'b0;
    case (op2_q)
      OP_ORIENT:   orientation_d = o3;
      OP_TRIANGLE: tri_d = tri_relation(o1, o2, o3);
      OP_CONE:     cone_d = cone_test(o1, o2, o3);
      default: begin
        orientation_d = ORI_COLLINEAR;
      end
    endcase
  end

  assign done_o              = done_q;
  assign orientation_o       = orientation_q;
  assign triangle_relation_o = tri_q;
  assign in_cone_o           = cone_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("accepted word produced no result after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result strobe without an accepted word");

  a_tri_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && op2_q != OP_TRIANGLE |=> triangle_relation_o == TRI_OUTSIDE)
    else $error("triangle field set for another operation");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(orientation_o != ORI_COLLINEAR && in_cone_o))
    else $error("orientation and cone fields both set");

endmodule
